/* rtl/core/arpc_pkg.sv */
`timescale 1ns / 1ps

package arpc_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int IP_W          = 32;
    localparam int MAC_W         = 48;
    localparam int SLOT_W        = 4;
    localparam int ENTRY_W       = IP_W + MAC_W;

    typedef logic [IDX_W-1:0] idx_t;

    localparam idx_t IDX_LAST = idx_t'(TABLE_ENTRIES - 1);

    typedef enum logic
    {
        FUNC_LEARN  = 1'b0,
        FUNC_LOOKUP = 1'b1
    } func_t;

    function automatic logic [SLOT_W-1:0] to_slot(input idx_t idx);
        logic [IDX_W+SLOT_W-1:0] wide;
        wide = {{SLOT_W{1'b0}}, idx};
        return wide[SLOT_W-1:0];
    endfunction

endpackage

/* rtl/core/arp_cache_learn_lookup.sv */
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// request   req_valid, req_stall   func, ip_addr, mac_addr
// response  rsp_valid, rsp_stall   found, mac_out, slot
//
// An item passes these steps: it is accepted; the registered read of the entry RAM is awaited;
// one entry per cycle is compared through the single read port of the entry RAM; a learn writes
// back its entry and the result is loaded.
// A lookup or learn that hits entry k ends the scan at entry k.
// Reset clears the valid bits and the control state; the RAM contents are not cleared.
// A stalled response holds the block before write-back; a new word is accepted
// while an earlier response still waits.

module arp_cache_learn_lookup
    import arpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  logic              func,
    input  logic [IP_W-1:0]   ip_addr,
    input  logic [MAC_W-1:0]  mac_addr,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output logic              found,
    output logic [MAC_W-1:0]  mac_out,
    output logic [SLOT_W-1:0] slot
);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t                   state_reg;
    func_t                    func_reg;
    logic [IP_W-1:0]          ip_reg;
    logic [MAC_W-1:0]         mac_reg;
    idx_t                     idx_reg;
    idx_t                     pidx_reg;
    logic                     pend_reg;
    logic                     hit_reg;
    idx_t                     hit_idx_reg;
    logic [MAC_W-1:0]         hit_mac_reg;
    logic                     free_found_reg;
    idx_t                     free_idx_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic                     rsp_valid_reg;
    logic                     found_reg;
    logic [MAC_W-1:0]         mac_out_reg;
    logic [SLOT_W-1:0]        slot_reg;
    idx_t                     out_idx_reg;

    logic [ENTRY_W-1:0] rd_data;
    logic [IP_W-1:0]    rd_ip;
    logic [MAC_W-1:0]   rd_mac;
    logic               cmp_hit;
    logic               cmp_free;
    logic               scan_last;
    logic               out_free;
    logic               ram_we;
    logic               ram_re;
    idx_t               wr_idx;
    idx_t               res_idx;

    assign rd_ip     = rd_data[MAC_W +: IP_W];
    assign rd_mac    = rd_data[MAC_W-1:0];
    assign cmp_hit   = pend_reg && valid_reg[pidx_reg] && (rd_ip == ip_reg);
    assign cmp_free  = pend_reg && !valid_reg[pidx_reg];
    assign scan_last = pend_reg && (pidx_reg == IDX_LAST);
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign ram_re    = (state_reg == ST_SCAN);
    assign ram_we    = (state_reg == ST_DONE) && out_free && (func_reg == FUNC_LEARN);
    assign wr_idx    = hit_reg ? hit_idx_reg : (free_found_reg ? free_idx_reg : '0);
    assign res_idx   = (func_reg == FUNC_LOOKUP) ? (hit_reg ? hit_idx_reg : '0) : wr_idx;

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign found     = found_reg;
    assign mac_out   = mac_out_reg;
    assign slot      = slot_reg;

    arpc_ram
    #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    )
    u_entry_ram
    (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (wr_idx),
        .wr_data ({ip_reg, mac_reg}),
        .rd_en   (ram_re),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            func_reg       <= FUNC_LEARN;
            ip_reg         <= '0;
            mac_reg        <= '0;
            idx_reg        <= '0;
            pidx_reg       <= '0;
            pend_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            hit_idx_reg    <= '0;
            hit_mac_reg    <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            valid_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
            mac_out_reg    <= '0;
            slot_reg       <= '0;
            out_idx_reg    <= '0;
        end
        else
        begin
            if (rsp_valid_reg && !rsp_stall && (state_reg != ST_DONE))
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_valid)
                    begin
                        func_reg       <= func_t'(func);
                        ip_reg         <= ip_addr;
                        mac_reg        <= mac_addr;
                        idx_reg        <= '0;
                        pend_reg       <= 1'b0;
                        hit_reg        <= 1'b0;
                        free_found_reg <= 1'b0;
                        state_reg      <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    pend_reg <= 1'b1;
                    pidx_reg <= idx_reg;
                    idx_reg  <= (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;
                    if (cmp_free && !free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= pidx_reg;
                    end
                    if (cmp_hit)
                    begin
                        hit_reg     <= 1'b1;
                        hit_idx_reg <= pidx_reg;
                        hit_mac_reg <= rd_mac;
                        state_reg   <= ST_DONE;
                    end
                    else if (scan_last)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        if (func_reg == FUNC_LEARN)
                        begin
                            valid_reg[wr_idx] <= 1'b1;
                        end
                        rsp_valid_reg <= 1'b1;
                        found_reg     <= hit_reg;
                        mac_out_reg   <= ((func_reg == FUNC_LOOKUP) && hit_reg) ?
                                         hit_mac_reg : '0;
                        slot_reg      <= to_slot(res_idx);
                        out_idx_reg   <= res_idx;
                        state_reg     <= ST_IDLE;
                    end
                    else
                    begin
                        rsp_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // A reported hit always names an entry that holds a valid mapping.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && found_reg |-> valid_reg[out_idx_reg])
    else $error("hit reported on an entry that is not valid");

    // Entries are never invalidated once learned.
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((valid_reg & $past(valid_reg)) == $past(valid_reg)))
    else $error("valid bit cleared after reset");

    // At most one entry becomes valid per cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ($countones(valid_reg ^ $past(valid_reg)) <= 1))
    else $error("more than one valid bit changed in a cycle");

    // The RAM is written only at write-back, never while a response would be overwritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == ST_DONE) && !(rsp_valid_reg && rsp_stall)))
    else $error("entry RAM written outside write-back");

endmodule

/* rtl/core/arpc_ram.sv */
`timescale 1ns / 1ps

module arpc_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
